### hdl/sbp_pkg.sv
package sbp_pkg;

  localparam int FRAC_W     = 16;
  localparam int CRD_W      = 32;
  localparam int PSUM_W     = CRD_W + 1;
  localparam int RAWY_W     = CRD_W + 3;
  localparam int DEPTH_W    = CRD_W + 2;
  localparam int MAG_W      = RAWY_W - 1;
  localparam int M2P_W      = 31;
  localparam int FAC_W      = 2 * M2P_W;
  localparam int HALF_W     = FAC_W / 2;
  localparam int PP_W       = HALF_W + MAG_W;
  localparam int NUM_W      = PP_W + HALF_W;
  localparam int DEN_W      = DEPTH_W - 1 + FRAC_W;
  localparam int Q_W        = 40;
  localparam int QO_W       = Q_W + 1;
  localparam int REM_W      = DEN_W + Q_W;
  localparam int DIV_LAT    = Q_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [DEPTH_W-1:0] NEAR_CLIP_Q16 = DEPTH_W'(6554);
  localparam logic [DEN_W-1:0]          UNIT_DEN      = DEN_W'(1) << FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORTHO_MODE,
    REG_METRES_TO_PIXELS,
    REG_FOCAL_LENGTH,
    REG_CAMERA_DISTANCE,
    REG_CENTRE_X,
    REG_CENTRE_Y,
    REG_DEBUG_ENABLE,
    REG_DEBUG_DISTANCE
  } sbp_reg_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] point_x;
    logic signed [CRD_W-1:0] point_y;
    logic signed [CRD_W-1:0] point_z;
    logic signed [CRD_W-1:0] offset_x;
    logic signed [CRD_W-1:0] offset_y;
    logic signed [CRD_W-1:0] offset_z;
    logic signed [CRD_W-1:0] floor_height;
  } sbp_item_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] screen_x;
    logic signed [CRD_W-1:0] screen_y;
    logic signed [CRD_W-1:0] pixel_scale;
    logic                    valid_res;
  } sbp_result_t;

  typedef struct packed {
    logic valid_res;
    logic neg_x;
    logic neg_y;
  } sbp_side_t;

endpackage

### hdl/sbp_div.sv
module sbp_div (
  input  logic                       clk,
  input  logic [sbp_pkg::NUM_W-1:0]  num,
  input  logic [sbp_pkg::DEN_W-1:0]  den,
  output logic [sbp_pkg::QO_W-1:0]   quo
);
  import sbp_pkg::*;

  localparam int DIFF_W = REM_W + 1;

  logic [REM_W-1:0]  rem_q  [Q_W+1];
  logic [DEN_W-1:0]  den_q  [Q_W+1];
  logic [Q_W-1:0]    bits_q [Q_W+1];
  logic              ov_q   [Q_W+1];
  logic [DIFF_W-1:0] diff   [Q_W];
  logic              round_up;

  // restoring division, one quotient bit per stage, msb first
  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      diff[k] = DIFF_W'(rem_q[k]) - (DIFF_W'(den_q[k]) << (Q_W - 1 - k));
    end
  end

  always_comb begin
    round_up = ((DEN_W + 1)'(rem_q[Q_W][DEN_W-1:0]) << 1) >= (DEN_W + 1)'(den_q[Q_W]);
  end

  always_ff @(posedge clk) begin
    rem_q[0]  <= num[REM_W-1:0];
    den_q[0]  <= den;
    bits_q[0] <= '0;
    ov_q[0]   <= num >= (NUM_W'(den) << Q_W);
    for (int k = 0; k < Q_W; k++) begin
      rem_q[k+1]  <= diff[k][DIFF_W-1] ? rem_q[k] : diff[k][REM_W-1:0];
      den_q[k+1]  <= den_q[k];
      bits_q[k+1] <= {bits_q[k][Q_W-2:0], ~diff[k][DIFF_W-1]};
      ov_q[k+1]   <= ov_q[k];
    end
    if (ov_q[Q_W]) begin
      quo <= QO_W'(1) << Q_W;
    end else begin
      quo <= QO_W'(bits_q[Q_W]) + QO_W'(round_up);
    end
  end

endmodule

### hdl/sprite_basis_projection_top.sv
// Projects one world point (point plus offset, Q16.16) to a screen position and pixel
// scale per clock, orthographic or perspective with near clip. A transaction is taken on
// any edge with start high and busy low; busy is high only during reset. Each result
// appears on result for one cycle with done, in order; the receiver cannot stall it,
// so it must take every done. The pipeline is five front stages (input register, add and
// multiply, select, split multiply, sum) plus the 42-stage restoring divider (operand
// register, one quotient bit per stage over 40 stages, rounding register), plus the
// output register.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at once and must
// only be made while no transaction is in flight.
module sprite_basis_projection_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  sbp_pkg::sbp_item_t              item,
  input  logic                            cfg_we,
  input  logic [sbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            done,
  output sbp_pkg::sbp_result_t            result
);
  import sbp_pkg::*;

  localparam int PRE_STAGES = 5;
  localparam int PIPE_LAT   = PRE_STAGES + DIV_LAT + 1;
  localparam int SUM_W      = QO_W + 2;

  logic                      ortho_mode;
  logic [M2P_W-1:0]          metres_to_pixels;
  logic [M2P_W-1:0]          focal_length;
  logic signed [CRD_W-1:0]   camera_distance;
  logic signed [CRD_W-1:0]   centre_x;
  logic signed [CRD_W-1:0]   centre_y;
  logic                      debug_enable;
  logic signed [CRD_W-1:0]   debug_distance;

  logic                      s0_vld;
  sbp_item_t                 s0_item;

  logic                      s1_vld;
  logic signed [PSUM_W-1:0]  s1_px, s1_py;
  logic signed [RAWY_W-1:0]  s1_rawy;
  logic signed [DEPTH_W-1:0] s1_depth;
  logic [FAC_W-1:0]          s1_mf;

  logic signed [RAWY_W-1:0]  sel_y;
  logic                      s2_vld;
  sbp_side_t                 s2_side;
  logic [FAC_W-1:0]          s2_fac;
  logic [MAG_W-1:0]          s2_mag_x, s2_mag_y;
  logic [DEN_W-1:0]          s2_den;

  logic                      s3_vld;
  sbp_side_t                 s3_side;
  logic [FAC_W-1:0]          s3_fac;
  logic [PP_W-1:0]           s3_pl_x, s3_ph_x, s3_pl_y, s3_ph_y;
  logic [DEN_W-1:0]          s3_den;

  logic                      s4_vld;
  sbp_side_t                 s4_side;
  logic [NUM_W-1:0]          s4_num_x, s4_num_y, s4_num_s;
  logic [DEN_W-1:0]          s4_den;

  logic [QO_W-1:0]           q_x, q_y, q_s;
  logic [DIV_LAT-1:0]        dl_vld;
  sbp_side_t                 dl_side [DIV_LAT];
  sbp_side_t                 out_side;
  sbp_result_t               result_next;

  function automatic logic signed [CRD_W-1:0] sat_add(logic signed [CRD_W-1:0] c,
                                                       logic [QO_W-1:0] q, logic neg);
    logic signed [SUM_W-1:0] sum;
    logic signed [CRD_W-1:0] res;
    sum = SUM_W'(c) + (neg ? -SUM_W'(q) : SUM_W'(q));
    if (sum[SUM_W-1:CRD_W-1] == '0 || sum[SUM_W-1:CRD_W-1] == '1) begin
      res = sum[CRD_W-1:0];
    end else if (sum[SUM_W-1]) begin
      res = {1'b1, {(CRD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(CRD_W-1){1'b1}}};
    end
    return res;
  endfunction

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      ortho_mode       <= 1'b0;
      metres_to_pixels <= M2P_W'(65536);
      focal_length     <= M2P_W'(65536);
      camera_distance  <= CRD_W'(65536);
      centre_x         <= '0;
      centre_y         <= '0;
      debug_enable     <= 1'b0;
      debug_distance   <= '0;
    end else if (cfg_we) begin
      case (sbp_reg_t'(cfg_index))
        REG_ORTHO_MODE:       ortho_mode       <= cfg_data[0];
        REG_METRES_TO_PIXELS: metres_to_pixels <= cfg_data[M2P_W-1:0];
        REG_FOCAL_LENGTH:     focal_length     <= cfg_data[M2P_W-1:0];
        REG_CAMERA_DISTANCE:  camera_distance  <= cfg_data[CRD_W-1:0];
        REG_CENTRE_X:         centre_x         <= cfg_data[CRD_W-1:0];
        REG_CENTRE_Y:         centre_y         <= cfg_data[CRD_W-1:0];
        REG_DEBUG_ENABLE:     debug_enable     <= cfg_data[0];
        REG_DEBUG_DISTANCE:   debug_distance   <= cfg_data[CRD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      dl_vld <= '0;
      done   <= 1'b0;
    end else begin
      s0_vld <= start && !busy;
      s1_vld <= s0_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      dl_vld <= {dl_vld[DIV_LAT-2:0], s4_vld};
      done   <= dl_vld[DIV_LAT-1];
    end
  end

  always_comb begin
    sel_y = ortho_mode ? RAWY_W'(s1_py) : s1_rawy;
  end

  // front end: sums, magnitudes and the wide numerators; side-band delay line and output register
  always_ff @(posedge clk) begin
    s0_item <= item;

    s1_px    <= PSUM_W'(s0_item.point_x) + PSUM_W'(s0_item.offset_x);
    s1_py    <= PSUM_W'(s0_item.point_y) + PSUM_W'(s0_item.offset_y);
    s1_rawy  <= RAWY_W'(s0_item.point_y) + RAWY_W'(s0_item.offset_y)
              + RAWY_W'(s0_item.point_z) + RAWY_W'(s0_item.offset_z)
              - RAWY_W'(s0_item.floor_height);
    s1_depth <= DEPTH_W'(camera_distance)
              + (debug_enable ? DEPTH_W'(debug_distance) : DEPTH_W'(0))
              - DEPTH_W'(s0_item.floor_height);
    s1_mf    <= FAC_W'(metres_to_pixels) * FAC_W'(focal_length);

    s2_side.valid_res <= ortho_mode || (s1_depth > NEAR_CLIP_Q16);
    s2_side.neg_x     <= s1_px[PSUM_W-1];
    s2_side.neg_y     <= sel_y[RAWY_W-1];
    s2_mag_x <= s1_px[PSUM_W-1] ? MAG_W'(-RAWY_W'(s1_px)) : MAG_W'(s1_px);
    s2_mag_y <= sel_y[RAWY_W-1] ? MAG_W'(-sel_y) : MAG_W'(sel_y);
    s2_fac   <= ortho_mode ? FAC_W'(metres_to_pixels) : s1_mf;
    s2_den   <= ortho_mode ? UNIT_DEN : {s1_depth[DEPTH_W-2:0], {FRAC_W{1'b0}}};

    s3_side <= s2_side;
    s3_fac  <= s2_fac;
    s3_den  <= s2_den;
    s3_pl_x <= PP_W'(s2_fac[HALF_W-1:0]) * PP_W'(s2_mag_x);
    s3_ph_x <= PP_W'(s2_fac[FAC_W-1:HALF_W]) * PP_W'(s2_mag_x);
    s3_pl_y <= PP_W'(s2_fac[HALF_W-1:0]) * PP_W'(s2_mag_y);
    s3_ph_y <= PP_W'(s2_fac[FAC_W-1:HALF_W]) * PP_W'(s2_mag_y);

    s4_side  <= s3_side;
    s4_den   <= s3_den;
    s4_num_x <= (NUM_W'(s3_ph_x) << HALF_W) + NUM_W'(s3_pl_x);
    s4_num_y <= (NUM_W'(s3_ph_y) << HALF_W) + NUM_W'(s3_pl_y);
    s4_num_s <= NUM_W'(s3_fac) << FRAC_W;

    dl_side[0] <= s4_side;
    for (int k = 1; k < DIV_LAT; k++) begin
      dl_side[k] <= dl_side[k-1];
    end

    result <= result_next;
  end

  sbp_div u_div_x (.clk(clk), .num(s4_num_x), .den(s4_den), .quo(q_x));
  sbp_div u_div_y (.clk(clk), .num(s4_num_y), .den(s4_den), .quo(q_y));
  sbp_div u_div_s (.clk(clk), .num(s4_num_s), .den(s4_den), .quo(q_s));

  assign out_side = dl_side[DIV_LAT-1];

  always_comb begin
    result_next = '0;
    if (out_side.valid_res) begin
      result_next.screen_x  = sat_add(centre_x, q_x, out_side.neg_x);
      result_next.screen_y  = sat_add(centre_y, q_y, out_side.neg_y);
      result_next.pixel_scale = (|q_s[QO_W-1:CRD_W-1]) ? {1'b0, {(CRD_W-1){1'b1}}}
                                                     : {1'b0, q_s[CRD_W-2:0]};
      result_next.valid_res = 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("transaction did not complete at pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without matching transaction");

  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.valid_res) |->
      (result.screen_x == 0 && result.screen_y == 0 && result.pixel_scale == 0))
    else $error("clipped result carries nonzero fields");

  a_scale_pos: assert property (@(posedge clk) disable iff (rst)
    done |-> !result.pixel_scale[CRD_W-1])
    else $error("pixel scale negative");
`endif

endmodule
